>>> rtl/msk_pkg.sv
package msk_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int NUM_STACKS_DEF  = 16;

	localparam int CMD_W  = 3;
	localparam int DATA_W = 32;
	localparam int TGT_W  = 4;
	localparam int STS_W  = 3;
	localparam int CUR_W  = 4;
	localparam int TOT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_CREATE = 3'd3,
		CMD_SWITCH = 3'd4
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK        = 3'd0,
		STS_OVERFLOW  = 3'd1,
		STS_UNDERFLOW = 3'd2,
		STS_LIMIT     = 3'd3,
		STS_BAD_INDEX = 3'd4
	} sts_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_WAIT = 2'd2,
		S_RESP = 2'd3
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture_in;
		logic exec;
		logic capture_rd;
		logic load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_read;
	} dp_sts_t;

	// address width for a memory of the given depth, at least one bit
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

>>> rtl/msk_ram.sv
module msk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = msk_pkg::addr_w(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/msk_ctrl.sv
module msk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  msk_pkg::dp_sts_t   dsts,
	output msk_pkg::ctl_cmd_t  ctl
);

	import msk_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_n = S_EXEC;
			S_EXEC: state_n = dsts.need_read ? S_WAIT : S_RESP;
			S_WAIT: state_n = S_RESP;
			S_RESP: if (!out_valid_q || out_ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == S_IDLE);
		ctl.capture_in = in_valid && (state_q == S_IDLE);
		ctl.exec       = (state_q == S_EXEC);
		ctl.capture_rd = (state_q == S_WAIT);
		ctl.load_out   = (state_q == S_RESP) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/msk_dp.sv
module msk_dp #(
	parameter int STACK_DEPTH = msk_pkg::STACK_DEPTH_DEF,
	parameter int NUM_STACKS  = msk_pkg::NUM_STACKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msk_pkg::ctl_cmd_t                 ctl,
	output msk_pkg::dp_sts_t                  dsts,
	input  logic        [msk_pkg::CMD_W-1:0]  command,
	input  logic signed [msk_pkg::DATA_W-1:0] push_value,
	input  logic        [msk_pkg::TGT_W-1:0]  target_stack,
	output logic signed [msk_pkg::DATA_W-1:0] data,
	output logic        [msk_pkg::STS_W-1:0]  status,
	output logic        [msk_pkg::CUR_W-1:0]  current_index,
	output logic        [msk_pkg::TOT_W-1:0]  stack_total
);

	import msk_pkg::*;

	localparam int SW = addr_w(NUM_STACKS);
	localparam int CW = $clog2(NUM_STACKS + 1);
	localparam int FW = $clog2(STACK_DEPTH + 1);
	localparam int ED = NUM_STACKS * STACK_DEPTH;
	localparam int EW = addr_w(ED);

	// held command
	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] value_q;
	logic [TGT_W-1:0]         target_q;

	// stack bookkeeping; fill_q caches the count of the current stack
	logic [SW-1:0] sel_q, sel_n;
	logic [CW-1:0] created_q, created_n;
	logic [FW-1:0] fill_q, fill_n;

	// result under construction and output word
	logic signed [DATA_W-1:0] res_data_q;
	sts_t                     res_sts_q, sts_n;
	logic signed [DATA_W-1:0] data_q;
	sts_t                     status_q;
	logic [CUR_W-1:0]         cur_q;
	logic [TOT_W-1:0]         total_q;

	// memories
	logic              ent_we, ent_re;
	logic [EW-1:0]     ent_addr;
	logic [DATA_W-1:0] ent_rdata;
	logic              fram_we, fram_re;
	logic [SW-1:0]     fram_raddr;
	logic [FW-1:0]     fram_rdata;

	logic [FW-1:0] pos;
	logic [31:0]   base;
	logic          need_read;

	always_comb begin
		base = 32'(sel_q) * 32'(STACK_DEPTH);
	end

	always_comb begin
		ent_we     = 1'b0;
		ent_re     = 1'b0;
		fram_we    = 1'b0;
		fram_re    = 1'b0;
		fram_raddr = SW'(target_q);
		need_read  = 1'b0;
		pos        = fill_q;
		sts_n      = STS_OK;
		fill_n     = fill_q;
		sel_n      = sel_q;
		created_n  = created_q;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (fill_q >= FW'(STACK_DEPTH)) begin
					sts_n = STS_OVERFLOW;
				end else begin
					ent_we = 1'b1;
					fill_n = FW'(fill_q + 1'b1);
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (fill_q == '0) begin
					sts_n = STS_UNDERFLOW;
				end else begin
					pos       = FW'(fill_q - 1'b1);
					ent_re    = 1'b1;
					need_read = 1'b1;
					if (cmd_q == CMD_POP) begin
						fill_n = pos;
					end
				end
			end
			CMD_CREATE: begin
				if (created_q >= CW'(NUM_STACKS)) begin
					sts_n = STS_LIMIT;
				end else begin
					// park the current count, open the new stack empty
					fram_we   = 1'b1;
					fill_n    = '0;
					sel_n     = SW'(created_q);
					created_n = CW'(created_q + 1'b1);
				end
			end
			CMD_SWITCH: begin
				if ((32'(target_q) < 32'(created_q)) &&
				    (32'(target_q) < 32'(NUM_STACKS))) begin
					sel_n = SW'(target_q);
					if (32'(target_q) != 32'(sel_q)) begin
						// park the current count, fetch the target's count
						fram_we   = 1'b1;
						fram_re   = 1'b1;
						need_read = 1'b1;
					end
				end else begin
					sts_n = STS_BAD_INDEX;
				end
			end
			default: ;
		endcase
		ent_addr = EW'(base + 32'(pos));
	end

	assign dsts.need_read = need_read;

	msk_ram #(
		.WIDTH(DATA_W),
		.DEPTH(ED)
	) u_entry_ram (
		.clk  (clk),
		.we   (ctl.exec && ent_we),
		.waddr(ent_addr),
		.wdata(value_q),
		.re   (ctl.exec && ent_re),
		.raddr(ent_addr),
		.rdata(ent_rdata)
	);

	msk_ram #(
		.WIDTH(FW),
		.DEPTH(NUM_STACKS)
	) u_fill_ram (
		.clk  (clk),
		.we   (ctl.exec && fram_we),
		.waddr(sel_q),
		.wdata(fill_q),
		.re   (ctl.exec && fram_re),
		.raddr(fram_raddr),
		.rdata(fram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= '0;
			created_q <= CW'(1);
			fill_q    <= '0;
		end else begin
			if (ctl.exec) begin
				sel_q     <= sel_n;
				created_q <= created_n;
				fill_q    <= fill_n;
			end else if (ctl.capture_rd && (cmd_q == CMD_SWITCH)) begin
				fill_q <= fram_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture_in) begin
			cmd_q    <= cmd_t'(command);
			value_q  <= push_value;
			target_q <= target_stack;
		end
		if (ctl.exec) begin
			res_data_q <= '0;
			res_sts_q  <= sts_n;
		end else if (ctl.capture_rd && (cmd_q != CMD_SWITCH)) begin
			res_data_q <= ent_rdata;
		end
		if (ctl.load_out) begin
			data_q   <= res_data_q;
			status_q <= res_sts_q;
			cur_q    <= CUR_W'(sel_q);
			total_q  <= TOT_W'(created_q);
		end
	end

	assign data          = data_q;
	assign status        = status_q;
	assign current_index = cur_q;
	assign stack_total   = total_q;

endmodule

>>> rtl/multi_stack_engine.sv
// Bank of LIFO stacks with one current stack.
// Input channel (in_valid/in_ready): one word carries command, push_value and
// target_stack. Commands: push, pop, peek, create stack, switch stack; unused
// codes do nothing and report ok.
// Output channel (out_valid/out_ready): one word per input word with data,
// status, current_index and stack_total, in input order.
// A word that needs no memory read goes straight from execute to respond;
// a pop or peek that finds an entry and a switch to another stack also pass
// through a read wait, since they wait on the registered read of the entry
// memory or the fill-count memory. One word is in flight at a time, so the
// block takes no new word until the current one has loaded the output
// register; the controller sequence is accept, execute, optional read wait,
// respond.
// Stall: a finished word sits in the output register; the block still takes
// the next input word and works on it, then holds its result until the
// output register frees up.
// Reset: arst_n clears the controller and the stack bookkeeping: stack 0 is
// current and empty, one stack exists. Entry memory contents are not cleared;
// only entries pushed are ever read.
module multi_stack_engine #(
	parameter int STACK_DEPTH = msk_pkg::STACK_DEPTH_DEF,
	parameter int NUM_STACKS  = msk_pkg::NUM_STACKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic        [msk_pkg::CMD_W-1:0]  command,
	input  logic signed [msk_pkg::DATA_W-1:0] push_value,
	input  logic        [msk_pkg::TGT_W-1:0]  target_stack,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [msk_pkg::DATA_W-1:0] data,
	output logic        [msk_pkg::STS_W-1:0]  status,
	output logic        [msk_pkg::CUR_W-1:0]  current_index,
	output logic        [msk_pkg::TOT_W-1:0]  stack_total
);

	import msk_pkg::*;

	ctl_cmd_t ctl;
	dp_sts_t  dsts;

	// sequence each word: accept, execute, wait on memory when needed, respond
	msk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dsts     (dsts),
		.ctl      (ctl)
	);

	// hold stack state, memories and the output word
	msk_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.NUM_STACKS (NUM_STACKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.dsts         (dsts),
		.command      (command),
		.push_value   (push_value),
		.target_stack (target_stack),
		.data         (data),
		.status       (status),
		.current_index(current_index),
		.stack_total  (stack_total)
	);

	// one word in flight: after an accept, drop ready for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a word is still in flight");

	// stack count never exceeds the bank size
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((stack_total != '0 && 32'(stack_total) <= 32'(NUM_STACKS))
			|| NUM_STACKS > 31))
		else $error("stack_total out of range");

	// current stack is always one that exists
	a_cur_exists: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((32'(current_index) < 32'(stack_total)) || NUM_STACKS > 31))
		else $error("current_index names a stack not yet created");

endmodule

>>> dv/msk_result_checker.sv
`timescale 1ns / 1ps

module msk_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic        [msk_pkg::CMD_W-1:0]  command,
	input  logic signed [msk_pkg::DATA_W-1:0] push_value,
	input  logic        [msk_pkg::TGT_W-1:0]  target_stack,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [msk_pkg::DATA_W-1:0] data,
	input  logic        [msk_pkg::STS_W-1:0]  status,
	input  logic        [msk_pkg::CUR_W-1:0]  current_index,
	input  logic        [msk_pkg::TOT_W-1:0]  stack_total,
	output int                                fail_count,
	output int                                pending
);

	import msk_pkg::*;

	localparam int DEPTH  = STACK_DEPTH_DEF;
	localparam int STACKS = NUM_STACKS_DEF;
	localparam int MAX_PRINTED = 100;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic        [STS_W-1:0]  status;
		logic        [CUR_W-1:0]  cur;
		logic        [TOT_W-1:0]  total;
	} stack_result_t;

	logic signed [DATA_W-1:0] stack_mem [STACKS][DEPTH];
	int unsigned              depth_of [STACKS];
	int unsigned              cur_stack;
	int unsigned              stacks_made;
	stack_result_t            pending_results [$];
	stack_result_t            oldest;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < MAX_PRINTED)
			$display("%0t mismatch %0s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// One command against the modeled stacks; returns the result it causes.
	function automatic stack_result_t execute_stack_command(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] value, input logic [TGT_W-1:0] tgt);
		stack_result_t res;
		int unsigned   fill;
		res.data   = '0;
		res.status = STS_OK;
		fill       = depth_of[cur_stack];
		case (cmd)
			CMD_PUSH: begin
				if (fill >= DEPTH) begin
					res.status = STS_OVERFLOW;
				end else begin
					stack_mem[cur_stack][fill] = value;
					depth_of[cur_stack] = fill + 1;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (fill == 0) begin
					res.status = STS_UNDERFLOW;
				end else begin
					res.data = stack_mem[cur_stack][fill-1];
					if (cmd == CMD_POP)
						depth_of[cur_stack] = fill - 1;
				end
			end
			CMD_CREATE: begin
				if (stacks_made >= STACKS) begin
					res.status = STS_LIMIT;
				end else begin
					depth_of[stacks_made] = 0;
					cur_stack = stacks_made;
					stacks_made++;
				end
			end
			CMD_SWITCH: begin
				if (tgt < stacks_made)
					cur_stack = tgt;
				else
					res.status = STS_BAD_INDEX;
			end
			default: ;
		endcase
		res.cur   = CUR_W'(cur_stack);
		res.total = TOT_W'(stacks_made);
		return res;
	endfunction

	// Results leave first, then the word taken at the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STACKS; s++) begin
				depth_of[s] = 0;
				for (int e = 0; e < DEPTH; e++)
					stack_mem[s][e] = '0;
			end
			cur_stack   = 0;
			stacks_made = 1;
			pending_results.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", data, '0);
				end else begin
					oldest = pending_results.pop_front();
					if (data !== oldest.data)
						report_mismatch("data", data, oldest.data);
					if (status !== oldest.status)
						report_mismatch("status", 32'(status), 32'(oldest.status));
					if (current_index !== oldest.cur)
						report_mismatch("current_index", 32'(current_index),
							32'(oldest.cur));
					if (stack_total !== oldest.total)
						report_mismatch("stack_total", 32'(stack_total),
							32'(oldest.total));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(execute_stack_command(command, push_value,
					target_stack));
			pending = pending_results.size();
		end
	end

endmodule

>>> dv/tb_multi_stack_engine.sv
`timescale 1ns / 1ps

module tb_multi_stack_engine;

	import msk_pkg::*;

	// command codes the block treats as no-ops
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	localparam int PHASE_ITEMS  = 450;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 16;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic        [CMD_W-1:0]  command;
	logic signed [DATA_W-1:0] push_value;
	logic        [TGT_W-1:0]  target_stack;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] data;
	logic        [STS_W-1:0]  status;
	logic        [CUR_W-1:0]  current_index;
	logic        [TOT_W-1:0]  stack_total;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	int stacks_seen;
	int quiet_cycles;
	bit hold_req;
	bit hold_done;

	multi_stack_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.push_value   (push_value),
		.target_stack (target_stack),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data         (data),
		.status       (status),
		.current_index(current_index),
		.stack_total  (stack_total)
	);

	msk_result_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.push_value   (push_value),
		.target_stack (target_stack),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data         (data),
		.status       (status),
		.current_index(current_index),
		.stack_total  (stack_total),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver: stall at the phase rate; on request, hold off once for a long
	// stretch so the block backs up and stops taking words.
	initial begin
		hold_done = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// Offer one word. Idle first at the phase rate, then hold valid and the
	// payload until the handshake. Call only at a rising edge.
	task automatic offer_word(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] value, input logic [TGT_W-1:0] tgt);
		int gap;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		push_value   <= value;
		target_stack <= tgt;
		do
			@(posedge clk);
		while (!in_ready);
		if (cmd == CMD_CREATE && stacks_seen < NUM_STACKS_DEF)
			stacks_seen++;
	endtask

	// Drop valid and wait until every pending result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly random values, with the signed extremes mixed in.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Random traffic built from bursts: push runs that can reach overflow, pop
	// and peek runs that can reach underflow, creates, switches (mostly to live
	// stacks), and a share of raw noise including the unused codes.
	task automatic run_random(input int count);
		int sent;
		int kind;
		int burst;
		logic [CMD_W-1:0] cmd;
		logic [TGT_W-1:0] tgt;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				burst = $urandom_range(18, 1);
				repeat (burst) offer_word(CMD_PUSH, pick_value(), TGT_W'($urandom));
				sent += burst;
			end else if (kind < 55) begin
				burst = $urandom_range(18, 1);
				repeat (burst) begin
					cmd = ($urandom_range(3) == 0) ? CMD_PEEK : CMD_POP;
					offer_word(cmd, $urandom, TGT_W'($urandom));
				end
				sent += burst;
			end else if (kind < 63) begin
				offer_word(CMD_CREATE, $urandom, TGT_W'($urandom));
				sent++;
			end else if (kind < 80) begin
				if ($urandom_range(3) != 0)
					tgt = TGT_W'($urandom_range(stacks_seen - 1));
				else
					tgt = TGT_W'($urandom);
				offer_word(CMD_SWITCH, $urandom, tgt);
				sent++;
			end else begin
				cmd = CMD_W'($urandom);
				offer_word(cmd, pick_value(), TGT_W'($urandom));
				if (cmd <= CMD_SWITCH)
					sent++;
			end
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		command        <= CMD_PUSH;
		push_value     <= '0;
		target_stack   <= '0;
		hold_req       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		stacks_seen    = 1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-stack reads, signed extremes through push and pop,
		// switches to stacks not yet created, a create, and the unused codes.
		offer_word(CMD_PEEK, '0, '0);
		offer_word(CMD_POP, '0, '0);
		offer_word(CMD_PUSH, 32'sh8000_0000, '0);
		offer_word(CMD_PUSH, 32'sh7fff_ffff, '0);
		offer_word(CMD_PUSH, '0, '0);
		offer_word(CMD_PUSH, '1, '1);
		offer_word(CMD_PEEK, '0, '0);
		offer_word(CMD_POP, '0, '0);
		offer_word(CMD_POP, '0, '0);
		offer_word(CMD_PEEK, '0, '0);
		offer_word(CMD_POP, '0, '0);
		offer_word(CMD_POP, '0, '0);
		offer_word(CMD_POP, '0, '0);
		offer_word(CMD_SWITCH, '0, 4'd15);
		offer_word(CMD_SWITCH, '0, 4'd1);
		offer_word(CMD_CREATE, '0, '0);
		offer_word(CMD_PUSH, 32'sh5a5a_a5a5, '0);
		offer_word(CMD_SWITCH, '0, 4'd0);
		offer_word(CMD_PEEK, '0, '0);
		offer_word(CMD_SWITCH, '0, 4'd1);
		offer_word(CMD_POP, '0, '0);
		for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
			offer_word(CMD_W'(c), '1, '1);
		offer_word(CMD_SWITCH, '0, 4'd0);
		drain_results();

		// Random phases: no idling, sender idle, receiver stalling, both.
		// The first phase also carries the long receiver hold-off.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 34 : 0;
			recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 34 : 0;
			if (phase == 0) begin
				run_random(150);
				hold_req = 1'b1;
				run_random(PHASE_ITEMS - 150);
			end else begin
				run_random(PHASE_ITEMS);
			end
			drain_results();
		end

		// Let any stray result show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/msk_pkg.sv
rtl/msk_ram.sv
rtl/msk_ctrl.sv
rtl/msk_dp.sv
rtl/multi_stack_engine.sv
dv/msk_result_checker.sv
dv/tb_multi_stack_engine.sv
